// ----- src/assert_macros.svh -----
// Assertion macros shared by the checkers of this project.
// Each expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ueid_pkg.sv -----
package ueid_pkg;

  localparam int VW    = 24;  // vertex number width
  localparam int NUM_W = 11;  // edge number field width
  localparam int CAP_W = 11;  // capacity register width

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [1:0] {
    ST_NEW     = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_ABSENT  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_t;

  // Ordered pair under search, broadcast to every cell.
  typedef struct packed {
    logic [VW-1:0] lo;
    logic [VW-1:0] hi;
    logic          ins;  // append at the fill point if no cell matches
  } query_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic active;
    logic hit;
  } tok_t;

endpackage

// ----- src/ueid_in_if.sv -----
interface ueid_in_if;
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [ueid_pkg::VW-1:0] vertex_a;
  logic [ueid_pkg::VW-1:0] vertex_b;

  modport source (output valid, func, vertex_a, vertex_b, input ready);
  modport sink (input valid, func, vertex_a, vertex_b, output ready);
endinterface

// ----- src/ueid_out_if.sv -----
interface ueid_out_if;
  logic                       valid;
  logic                       ready;
  logic [ueid_pkg::NUM_W-1:0] edge_number;
  logic                       reversed;
  logic [1:0]                 status;

  modport source (output valid, edge_number, reversed, status, input ready);
  modport sink (input valid, edge_number, reversed, status, output ready);
endinterface

// ----- src/ueid_cell.sv -----
module ueid_cell #(
  parameter int IDX = 0,
  parameter int CW  = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ueid_pkg::query_t query,
  input  logic [CW-1:0]    cnt,
  input  ueid_pkg::tok_t   tok_i,
  input  logic [CW-1:0]    num_i,
  output ueid_pkg::tok_t   tok_o,
  output logic [CW-1:0]    num_o
);

  logic [ueid_pkg::VW-1:0] lo_r;
  logic [ueid_pkg::VW-1:0] hi_r;
  ueid_pkg::tok_t          tok_r;
  ueid_pkg::tok_t          tok_nxt;
  logic [CW-1:0]           num_r;
  logic [CW-1:0]           num_nxt;
  logic                    used;
  logic                    match;
  logic                    first_hit;
  logic                    wr;

  assign used      = CW'(IDX) < cnt;
  assign match     = used && (lo_r == query.lo) && (hi_r == query.hi);
  assign first_hit = tok_i.active && !tok_i.hit && match;
  // All filled cells lie ahead of the fill point, so the search is complete here.
  assign wr        = tok_i.active && !tok_i.hit && query.ins && (cnt == CW'(IDX));

  always_comb begin
    tok_nxt.active = tok_i.active;
    tok_nxt.hit    = tok_i.hit || first_hit;
    num_nxt        = first_hit ? CW'(IDX + 1) : num_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    if (wr) begin
      lo_r <= query.lo;
      hi_r <= query.hi;
    end
  end

  assign tok_o = tok_r;
  assign num_o = num_r;

endmodule

// ----- src/ueid_ctrl.sv -----
module ueid_ctrl #(
  parameter int EDGES_MAX = 1024,
  parameter int CW        = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ueid_in_if.sink                       in_if,
  ueid_out_if.source                    out_if,
  input  logic                          cfg_we,
  input  logic [ueid_pkg::CAP_W-1:0]    cfg_wdata,
  output ueid_pkg::query_t              query,
  output logic                          start,
  output logic [CW-1:0]                 cnt,
  input  ueid_pkg::tok_t                tail_tok,
  input  logic [CW-1:0]                 tail_num
);

  localparam int LW = (CW > ueid_pkg::CAP_W) ? CW : ueid_pkg::CAP_W;
  localparam int WW = (CW > ueid_pkg::NUM_W) ? CW : ueid_pkg::NUM_W;

  ueid_pkg::state_t             state_r, state_nxt;
  logic [ueid_pkg::CAP_W-1:0]   cap_r;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [ueid_pkg::VW-1:0]      lo_r, hi_r;
  logic                         ins_r, func_r, rev_r;
  logic                         start_r, start_nxt;
  logic [CW-1:0]                res_num_r, res_num_nxt;
  ueid_pkg::status_t            res_st_r, res_st_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [ueid_pkg::NUM_W-1:0]   out_num_r;
  logic                         out_rev_r;
  ueid_pkg::status_t            out_st_r;
  logic                         in_fire;
  logic                         load;
  logic                         rev_in;
  logic                         room;
  logic [WW-1:0]                num_wide;

  assign rev_in = in_if.vertex_a > in_if.vertex_b;
  assign room   = (LW'(cnt_r) < LW'(cap_r)) && (cnt_r < CW'(EDGES_MAX));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    start_nxt     = 1'b0;
    res_num_nxt   = res_num_r;
    res_st_nxt    = res_st_r;
    load          = 1'b0;
    in_fire       = 1'b0;
    in_if.ready   = 1'b0;
    out_valid_nxt = out_valid_r && !out_if.ready;
    case (state_r)
      ueid_pkg::S_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          in_fire   = 1'b1;
          start_nxt = 1'b1;
          state_nxt = ueid_pkg::S_SCAN;
        end
      end
      ueid_pkg::S_SCAN: begin
        if (tail_tok.active) begin
          state_nxt = ueid_pkg::S_HOLD;
          if (tail_tok.hit) begin
            res_num_nxt = tail_num;
            res_st_nxt  = ueid_pkg::ST_PRESENT;
          end else if (func_r) begin
            res_num_nxt = '0;
            res_st_nxt  = ueid_pkg::ST_ABSENT;
          end else if (ins_r) begin
            cnt_nxt     = cnt_r + CW'(1);
            res_num_nxt = cnt_r + CW'(1);
            res_st_nxt  = ueid_pkg::ST_NEW;
          end else begin
            res_num_nxt = '0;
            res_st_nxt  = ueid_pkg::ST_FULL;
          end
        end
      end
      ueid_pkg::S_HOLD: begin
        // Wait for the output register to drain.
        if (!out_valid_r || out_if.ready) begin
          load          = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ueid_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ueid_pkg::S_IDLE;
      end
    endcase
  end

  assign num_wide = WW'(res_num_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ueid_pkg::S_IDLE;
      cap_r       <= ueid_pkg::CAP_RESET;
      cnt_r       <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_num_r <= res_num_nxt;
    res_st_r  <= res_st_nxt;
    if (in_fire) begin
      lo_r   <= rev_in ? in_if.vertex_b : in_if.vertex_a;
      hi_r   <= rev_in ? in_if.vertex_a : in_if.vertex_b;
      rev_r  <= rev_in;
      func_r <= in_if.func;
      ins_r  <= !in_if.func && room;
    end
    if (load) begin
      out_num_r <= num_wide[ueid_pkg::NUM_W-1:0];
      out_rev_r <= rev_r;
      out_st_r  <= res_st_r;
    end
  end

  assign query.lo  = lo_r;
  assign query.hi  = hi_r;
  assign query.ins = ins_r;
  assign start     = start_r;
  assign cnt       = cnt_r;

  assign out_if.valid       = out_valid_r;
  assign out_if.edge_number = out_num_r;
  assign out_if.reversed    = out_rev_r;
  assign out_if.status      = out_st_r;

endmodule

// ----- src/undirected_edge_id_table.sv -----
// Channel   Direction  Handshake     Payload
// in_if     input      valid/ready   func, vertex_a, vertex_b
// out_if    output     valid/ready   edge_number, reversed, status
// cfg       input      cfg_we        cfg_wdata (capacity)
//
// One item at a time: a search token walks the row of EDGES_MAX cells, one cell per
// cycle; the result of an item is loaded into the output register before the next
// item can be taken.
// The cell at the fill point stores a new pair as the token passes it.
// Reset is synchronous; it clears the edge count and restores capacity to 1024.
// A result left in the output register holds back the next one, and input waits for it.
module undirected_edge_id_table #(
  parameter int EDGES_MAX = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ueid_in_if.sink                    in_if,
  ueid_out_if.source                 out_if,
  input  logic                       cfg_we,
  input  logic [ueid_pkg::CAP_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(EDGES_MAX + 1);

  ueid_pkg::query_t query;
  logic             start;
  logic [CW-1:0]    cnt;
  ueid_pkg::tok_t   tok [EDGES_MAX+1];
  logic [CW-1:0]    num [EDGES_MAX+1];

  ueid_ctrl #(
    .EDGES_MAX (EDGES_MAX),
    .CW        (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .query     (query),
    .start     (start),
    .cnt       (cnt),
    .tail_tok  (tok[EDGES_MAX]),
    .tail_num  (num[EDGES_MAX])
  );

  assign tok[0].active = start;
  assign tok[0].hit    = 1'b0;
  assign num[0]        = '0;

  for (genvar g = 0; g < EDGES_MAX; g++) begin : g_cell
    ueid_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .query (query),
      .cnt   (cnt),
      .tok_i (tok[g]),
      .num_i (num[g]),
      .tok_o (tok[g+1]),
      .num_o (num[g+1])
    );
  end

endmodule

// ----- src/ueid_checker.sv -----
`include "assert_macros.svh"

module ueid_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ueid_pkg::NUM_W-1:0] out_edge_number,
  input logic [1:0]                 out_status
);

  logic fail_st;
  logic out_stall;

  assign fail_st   = (out_status == ueid_pkg::ST_FULL) || (out_status == ueid_pkg::ST_ABSENT);
  assign out_stall = out_valid && !out_ready;

  // Only one item in flight.
  `ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item accepted")

  `ASSERT_IMPL(a_fail_zero, out_valid && fail_st, out_edge_number == '0, "nonzero failure number")

  `ASSERT_NEXT(a_out_hold, out_stall, out_valid, "result dropped before being taken")

  `ASSERT_NEXT(a_num_stable, out_stall, $stable(out_edge_number), "stalled number changed")

  `ASSERT_NEXT(a_st_stable, out_stall, $stable(out_status), "stalled status changed")

endmodule

bind undirected_edge_id_table ueid_checker u_ueid_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_edge_number (out_if.edge_number),
  .out_status      (out_if.status)
);

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EDGE_SLOTS    = 1024;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 56;
  localparam int LONG_HOLD     = 6000;
  localparam int VW            = ueid_pkg::VW;
  localparam int NUM_W         = ueid_pkg::NUM_W;
  localparam int CAP_W         = ueid_pkg::CAP_W;

  typedef enum bit {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } edge_op_t;

  typedef struct {
    logic [NUM_W-1:0]  number;
    logic              reversed;
    ueid_pkg::status_t status;
  } edge_result_t;

  // Mirror of the edge table: ordered pairs in arrival order, plus the results still owed.
  class edge_table_scoreboard;
    logic [VW-1:0] low_end[$];
    logic [VW-1:0] high_end[$];
    int unsigned   capacity = ueid_pkg::CAP_RESET;
    edge_result_t  awaited[$];
    int            errors = 0;

    function int unsigned find_pair(logic [VW-1:0] lo, logic [VW-1:0] hi);
      foreach (low_end[i])
        if (low_end[i] == lo && high_end[i] == hi)
          return i + 1;
      return 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_item(edge_op_t op, logic [VW-1:0] a, logic [VW-1:0] b);
      logic [VW-1:0] lo;
      logic [VW-1:0] hi;
      int unsigned   num;
      int unsigned   limit;
      edge_result_t  r;
      r.reversed = a > b;
      lo = r.reversed ? b : a;
      hi = r.reversed ? a : b;
      num = find_pair(lo, hi);
      limit = (capacity > EDGE_SLOTS) ? EDGE_SLOTS : capacity;
      if (num != 0) begin
        r.status = ueid_pkg::ST_PRESENT;
      end else if (op == OP_LOOKUP) begin
        r.status = ueid_pkg::ST_ABSENT;
      end else if (low_end.size() >= limit) begin
        r.status = ueid_pkg::ST_FULL;
      end else begin
        low_end.push_back(lo);
        high_end.push_back(hi);
        num = low_end.size();
        r.status = ueid_pkg::ST_NEW;
      end
      r.number = num[NUM_W-1:0];
      awaited.push_back(r);
    endfunction

    function void check_result(logic [NUM_W-1:0] number, logic reversed,
                               logic [1:0] status);
      edge_result_t r;
      if (awaited.size() == 0) begin
        $display("%0t: result with no item outstanding: edge_number %0d reversed %0b status %0d",
                 $time, number, reversed, status);
        errors++;
        return;
      end
      r = awaited.pop_front();
      if (number !== r.number) begin
        $display("%0t: edge_number expected %0d, got %0d", $time, r.number, number);
        errors++;
      end
      if (reversed !== r.reversed) begin
        $display("%0t: reversed expected %0b, got %0b", $time, r.reversed, reversed);
        errors++;
      end
      if (status !== r.status) begin
        $display("%0t: status expected %0d, got %0d", $time, r.status, status);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CAP_W-1:0]     cfg_wdata;
  bit                   sender_gaps = 1'b1;
  bit                   sink_stalls = 1'b1;
  int                   hold_request = 0;
  int unsigned          cycles = 0;
  edge_table_scoreboard sb = new;

  ueid_in_if  in_ch ();
  ueid_out_if out_ch ();

  undirected_edge_id_table #(
    .EDGES_MAX(EDGE_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_item(edge_op_t'(in_ch.func), in_ch.vertex_a, in_ch.vertex_b);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.edge_number, out_ch.reversed, out_ch.status);
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Result side: long hold on request, otherwise short random stalls.
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        n = hold_request;
        hold_request = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Leaves valid high on return so that the next item follows without a gap.
  task automatic send_item(edge_op_t op, logic [VW-1:0] a, logic [VW-1:0] b);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= op;
    in_ch.vertex_a <= a;
    in_ch.vertex_b <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and hold until every owed result has come back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.capacity = value;
  endtask

  task automatic random_item();
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    logic [VW-1:0] t;
    edge_op_t      op;
    int unsigned   pick;
    int unsigned   k;
    op = ($urandom_range(0, 2) == 0) ? OP_LOOKUP : OP_INSERT;
    pick = $urandom_range(0, 9);
    if (pick < 4 && sb.low_end.size() != 0) begin
      k = $urandom_range(0, sb.low_end.size() - 1);
      a = sb.low_end[k];
      b = sb.high_end[k];
    end else if (pick < 6) begin
      // narrow vertex range: repeats, collisions and equal ends
      a = VW'($urandom_range(0, 15));
      b = VW'($urandom_range(0, 15));
    end else begin
      a = VW'($urandom);
      b = ($urandom_range(0, 15) == 0) ? a : VW'($urandom);
    end
    if ($urandom_range(0, 1) == 1) begin
      t = a;
      a = b;
      b = t;
    end
    send_item(op, a, b);
  endtask

  initial begin
    logic [CAP_W-1:0] cap;
    int unsigned      filled;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.func     <= OP_INSERT;
    in_ch.vertex_a <= '0;
    in_ch.vertex_b <= '0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, equal ends, reversed pairs, extremes
    send_item(OP_LOOKUP, 24'd5, 24'd9);
    send_item(OP_INSERT, 24'h000000, 24'h000000);
    send_item(OP_INSERT, 24'hFFFFFF, 24'h000000);
    send_item(OP_INSERT, 24'h000000, 24'hFFFFFF);
    send_item(OP_LOOKUP, 24'hFFFFFF, 24'h000000);
    send_item(OP_INSERT, 24'hFFFFFF, 24'hFFFFFF);
    send_item(OP_INSERT, 24'hAAAAAA, 24'h555555);
    send_item(OP_LOOKUP, 24'h555555, 24'hAAAAAA);
    send_item(OP_LOOKUP, 24'h123456, 24'h654321);
    send_item(OP_LOOKUP, 24'h654321, 24'h123456);

    // zero capacity: new pairs refused, stored ones still found
    settle();
    write_capacity(11'd0);
    send_item(OP_INSERT, 24'd1, 24'd2);
    send_item(OP_INSERT, 24'd2, 24'd1);
    send_item(OP_INSERT, 24'd0, 24'd0);
    send_item(OP_LOOKUP, 24'hAAAAAA, 24'h555555);

    // room for two more, then full
    settle();
    write_capacity(11'd6);
    send_item(OP_INSERT, 24'd1, 24'd2);
    send_item(OP_INSERT, 24'd3, 24'd4);
    send_item(OP_INSERT, 24'd5, 24'd6);

    // capacity below the stored count
    settle();
    write_capacity(11'd1);
    send_item(OP_INSERT, 24'd7, 24'd8);
    send_item(OP_LOOKUP, 24'd3, 24'd4);
    send_item(OP_INSERT, 24'd4, 24'd3);

    // capacity above the table size
    settle();
    write_capacity(11'd2047);
    send_item(OP_INSERT, 24'h800000, 24'h7FFFFF);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      filled = sb.low_end.size();
      if (p == RANDOM_PHASES - 1) begin
        cap = ueid_pkg::CAP_RESET;
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            cap = 11'd2047;
          end
          1: begin
            cap = CAP_W'(filled + $urandom_range(0, 20));
          end
          2: begin
            cap = CAP_W'($urandom_range(0, filled));
          end
          default: begin
            cap = CAP_W'($urandom_range(0, 2047));
          end
        endcase
      end
      write_capacity(cap);
      // stall the result side long enough for the block to back up
      if (p == 2)
        hold_request = LONG_HOLD;
      repeat (PHASE_ITEMS) random_item();
    end

    settle();
    repeat (EDGE_SLOTS + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
